// ===== hw/rtl/triangle_area_min_max_defines.svh =====
// Assertion macros for the triangle area tracker.
`ifndef TRIANGLE_AREA_MIN_MAX_DEFINES_SVH
`define TRIANGLE_AREA_MIN_MAX_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define TAM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tam assertion failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define TAM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tam assertion failed");

`endif

// ===== hw/rtl/tam_pkg.sv =====
// Shared constants and types of the triangle area tracker.
package tam_pkg;

    localparam int SIDE_BITS_DEF = 16;
    localparam int AREA_W        = 33;
    localparam int OUT_DATA_W    = ((3 * AREA_W + 7) / 8) * 8;
    localparam int OUT_USER_W    = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PROD,
        ST_ROOT,
        ST_HOLD
    } t_state;

endpackage

// ===== hw/rtl/tam_ser_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module tam_ser_mul #(
    parameter int XW = 18,
    parameter int YW = 17
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [XW-1:0]      i_x,
    input  logic [YW-1:0]      i_y,
    output logic               o_done,
    output logic [XW+YW-1:0]   o_p
);

    localparam int CNT_W = $clog2(YW);

    logic [XW-1:0]    r_x;
    logic [XW+YW-1:0] r_p, n_p;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [XW:0]      w_sum;

    assign w_sum = {1'b0, r_p[XW+YW-1:YW]} + (r_p[0] ? {1'b0, r_x} : {(XW+1){1'b0}});
    assign n_p   = {w_sum, r_p[YW-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(YW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_p <= {{XW{1'b0}}, i_y};
        end else if (r_busy) begin
            r_p <= n_p;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

// ===== hw/rtl/tam_isqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module tam_isqrt #(
    parameter int NW = 66
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NW-1:0]   i_n,
    output logic            o_done,
    output logic [NW/2-1:0] o_root
);

    localparam int RW    = NW / 2;
    localparam int REM_W = RW + 2;
    localparam int CNT_W = $clog2(RW);

    logic [NW-1:0]    r_n;
    logic [REM_W-1:0] r_rem;
    logic [RW-1:0]    r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [REM_W+1:0] w_rem_sh;
    logic [REM_W+1:0] w_trial;
    logic [REM_W+1:0] w_diff;
    logic             w_fit;

    assign w_rem_sh = {r_rem, r_n[NW-1:NW-2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_diff   = w_rem_sh - w_trial;
    assign w_fit    = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n <= {r_n[NW-3:0], 2'b00};
            if (w_fit) begin
                r_rem  <= w_diff[REM_W-1:0];
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[REM_W-1:0];
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hw/rtl/triangle_area_min_max.sv =====
// A valid triangle runs through the bit-serial multipliers (SIDE_BITS+1 and 2*SIDE_BITS+2
// steps) and the root unit (2*SIDE_BITS+1 steps) before its result is loaded to the output;
// an invalid triangle skips them. A new item is taken only when the controller is idle,
// after the last result has been loaded to the output.
// Reset (i_rst_n low, synchronous): largest 0, smallest all ones, seen flag clear,
// output empty, controller idle.
`include "triangle_area_min_max_defines.svh"

module triangle_area_min_max #(
    parameter int SIDE_BITS = tam_pkg::SIDE_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    // side_a, side_b, side_c from the lowest bit up, zero padding above
    input  logic [((3*SIDE_BITS+7)/8)*8-1:0]          i_s_tdata,
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    // area_x4, largest_area, smallest_area from the lowest bit up, zero padding above
    output logic [tam_pkg::OUT_DATA_W-1:0]            o_m_tdata,
    // is_triangle, any_seen from the lowest bit up
    output logic [tam_pkg::OUT_USER_W-1:0]            o_m_tuser
);

    localparam int S      = SIDE_BITS;
    localparam int AW     = tam_pkg::AREA_W;
    localparam int M1_W   = 2 * S + 3;
    localparam int M2_W   = 2 * S + 2;
    localparam int PROD_W = 4 * S + 2;
    localparam int ROOT_W = 2 * S + 1;

    tam_pkg::t_state r_state, n_state;

    logic [S-1:0]      w_a, w_b, w_c;
    logic [S:0]        w_bc, w_ac, w_ab;
    logic [S:0]        w_fa, w_fb, w_fc;
    logic [S+1:0]      w_s;
    logic              w_valid;
    logic              w_accept;
    logic              w_load;
    logic              w_mul_start, w_prod_start, w_root_start;
    logic              w_m1_done, w_m2_done, w_pr_done, w_rt_done;
    logic [M1_W-1:0]   w_m1;
    logic [M2_W-1:0]   w_m2;
    logic [M1_W+M2_W-1:0] w_prod_full;
    logic [ROOT_W-1:0] w_root;
    logic [AW-1:0]     w_area_sat;

    logic [AW-1:0]     r_area, n_area;
    logic              r_tri, n_tri;
    logic              r_out_valid, n_out_valid;
    logic [AW-1:0]     r_out_area;
    logic              r_out_tri;
    logic [AW-1:0]     r_max, n_max;
    logic [AW-1:0]     r_min, n_min;
    logic              r_seen, n_seen;

    assign w_a = i_s_tdata[S-1:0];
    assign w_b = i_s_tdata[2*S-1:S];
    assign w_c = i_s_tdata[3*S-1:2*S];

    assign w_bc = {1'b0, w_b} + {1'b0, w_c};
    assign w_ac = {1'b0, w_a} + {1'b0, w_c};
    assign w_ab = {1'b0, w_a} + {1'b0, w_b};
    assign w_s  = {2'b00, w_a} + {2'b00, w_b} + {2'b00, w_c};
    assign w_fa = w_bc - {1'b0, w_a};
    assign w_fb = w_ac - {1'b0, w_b};
    assign w_fc = w_ab - {1'b0, w_c};
    assign w_valid = ({1'b0, w_a} < w_bc) && ({1'b0, w_b} < w_ac) && ({1'b0, w_c} < w_ab);

    assign o_s_tready = (r_state == tam_pkg::ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    tam_ser_mul #(.XW(S + 2), .YW(S + 1)) u_mul_sf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_x     (w_s),
        .i_y     (w_fa),
        .o_done  (w_m1_done),
        .o_p     (w_m1)
    );

    tam_ser_mul #(.XW(S + 1), .YW(S + 1)) u_mul_bc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_x     (w_fb),
        .i_y     (w_fc),
        .o_done  (w_m2_done),
        .o_p     (w_m2)
    );

    tam_ser_mul #(.XW(M1_W), .YW(M2_W)) u_mul_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_prod_start),
        .i_x     (w_m1),
        .i_y     (w_m2),
        .o_done  (w_pr_done),
        .o_p     (w_prod_full)
    );

    tam_isqrt #(.NW(PROD_W)) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_n     (w_prod_full[PROD_W-1:0]),
        .o_done  (w_rt_done),
        .o_root  (w_root)
    );

    generate
        if (ROOT_W > AW) begin : g_sat
            assign w_area_sat = (|w_root[ROOT_W-1:AW]) ? {AW{1'b1}} : w_root[AW-1:0];
        end else begin : g_ext
            assign w_area_sat = AW'(w_root);
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_area       = r_area;
        n_tri        = r_tri;
        n_out_valid  = r_out_valid;
        n_max        = r_max;
        n_min        = r_min;
        n_seen       = r_seen;
        w_mul_start  = 1'b0;
        w_prod_start = 1'b0;
        w_root_start = 1'b0;
        w_load       = 1'b0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tam_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_tri  = w_valid;
                    n_area = '0;
                    if (w_valid) begin
                        w_mul_start = 1'b1;
                        n_state     = tam_pkg::ST_MUL;
                    end else begin
                        n_state = tam_pkg::ST_HOLD;
                    end
                end
            end
            tam_pkg::ST_MUL: begin
                if (w_m1_done && w_m2_done) begin
                    w_prod_start = 1'b1;
                    n_state      = tam_pkg::ST_PROD;
                end
            end
            tam_pkg::ST_PROD: begin
                if (w_pr_done) begin
                    w_root_start = 1'b1;
                    n_state      = tam_pkg::ST_ROOT;
                end
            end
            tam_pkg::ST_ROOT: begin
                if (w_rt_done) begin
                    n_area  = w_area_sat;
                    n_state = tam_pkg::ST_HOLD;
                end
            end
            tam_pkg::ST_HOLD: begin
                if (!r_out_valid || i_m_tready) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = tam_pkg::ST_IDLE;
                    if (r_tri) begin
                        n_seen = 1'b1;
                        if (r_area > r_max) begin
                            n_max = r_area;
                        end
                        if (r_area < r_min) begin
                            n_min = r_area;
                        end
                    end
                end
            end
            default: begin
                n_state = tam_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tam_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_max       <= '0;
            r_min       <= {AW{1'b1}};
            r_seen      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_max       <= n_max;
            r_min       <= n_min;
            r_seen      <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_area <= n_area;
        r_tri  <= n_tri;
        if (w_load) begin
            r_out_area <= r_area;
            r_out_tri  <= r_tri;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(tam_pkg::OUT_DATA_W - 3 * AW){1'b0}}, r_min, r_max, r_out_area};
    assign o_m_tuser  = {r_seen, r_out_tri};

    `TAM_ASSERT_NOW(a_min_le_max, r_seen, r_min <= r_max)
    `TAM_ASSERT_NOW(a_bad_zero_area, r_out_valid && !r_out_tri, r_out_area == '0)
    `TAM_ASSERT_NEXT(a_bad_skips_math, w_accept && !w_valid, r_state == tam_pkg::ST_HOLD)
    `TAM_ASSERT_NOW(a_tri_sets_seen, r_out_valid && r_out_tri, r_seen)

endmodule
